// File: rtl/core/rgb_bilateral_filter_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RGB bilateral filter
// Shared helpers for concurrent checks, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef RGB_BILATERAL_FILTER_DEFINES_SVH
`define RGB_BILATERAL_FILTER_DEFINES_SVH

// Same-cycle implication.
`define RBF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_bilateral_filter: assertion failed");

// Next-cycle implication.
`define RBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_bilateral_filter: assertion failed");

`endif

// File: rtl/core/rbf_pkg.sv
// ---------------------------------------------------------------------------
// rbf_pkg
// Types and constants shared by the bilateral filter modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbf_pkg;

  // Image geometry: the coordinate fields are 7 bits wide.
  localparam int MAX_WIDTH            = 128;
  localparam int MAX_HEIGHT           = 128;
  localparam int DEF_MAX_RADIUS       = 8;
  localparam int RANGE_TABLE_SIZE     = 256;
  localparam int WEIGHT_FRACTION_BITS = 15;

  localparam int COORD_W  = 7;
  localparam int SAMPLE_W = 8;
  localparam int WEIGHT_W = 16;
  localparam int PIX_W    = 3 * SAMPLE_W;
  localparam int FRAME_AW = 2 * COORD_W;
  localparam int RANGE_AW = 8;
  localparam int WT_W     = WEIGHT_W + 1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_LOAD_PIXEL   = 2'd0,
    OP_LOAD_RANGE   = 2'd1,
    OP_LOAD_SPATIAL = 2'd2,
    OP_FILTER       = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_FILTER_RADIUS = 2'd2;

  typedef struct packed {
    op_t                 operation;
    logic [COORD_W-1:0]  x_coord;
    logic [COORD_W-1:0]  y_coord;
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
    logic [RANGE_AW-1:0] table_index;
    logic [WEIGHT_W-1:0] weight_value;
  } rbf_in_t;

  typedef struct packed {
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic [SAMPLE_W-1:0] out_red;
    logic [SAMPLE_W-1:0] out_green;
    logic [SAMPLE_W-1:0] out_blue;
  } rbf_out_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic       clear;
    logic       mul_weight;
    logic       mul_sample;
    logic       accumulate;
    logic [1:0] ch;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/rbf_store.sv
// ---------------------------------------------------------------------------
// rbf_store
// Frame store, range-weight table and spatial-weight table, each with one
// write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbf_store
  import rbf_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic                clk,
  input  wire logic                pix_we,
  input  wire logic [FRAME_AW-1:0] pix_waddr,
  input  wire logic [PIX_W-1:0]    pix_wdata,
  input  wire logic                pix_re,
  input  wire logic [FRAME_AW-1:0] pix_raddr,
  output logic      [PIX_W-1:0]    pix_rdata,
  input  wire logic                rng_we,
  input  wire logic [RANGE_AW-1:0] rng_waddr,
  input  wire logic [WEIGHT_W-1:0] rng_wdata,
  input  wire logic                rng_re,
  input  wire logic [RANGE_AW-1:0] rng_raddr,
  output logic      [WEIGHT_W-1:0] rng_rdata,
  input  wire logic                sp_we,
  input  wire logic [((MAX_RADIUS+1)*(MAX_RADIUS+1) > 1 ?
                      $clog2((MAX_RADIUS+1)*(MAX_RADIUS+1)) : 1)-1:0] sp_waddr,
  input  wire logic [WEIGHT_W-1:0] sp_wdata,
  input  wire logic                sp_re,
  input  wire logic [((MAX_RADIUS+1)*(MAX_RADIUS+1) > 1 ?
                      $clog2((MAX_RADIUS+1)*(MAX_RADIUS+1)) : 1)-1:0] sp_raddr,
  output logic      [WEIGHT_W-1:0] sp_rdata
);

  localparam int SP_DEPTH  = (MAX_RADIUS + 1) * (MAX_RADIUS + 1);
  localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [PIX_W-1:0]    frame_mem [PIX_DEPTH];
  logic [WEIGHT_W-1:0] range_mem [RANGE_TABLE_SIZE];
  logic [WEIGHT_W-1:0] spat_mem  [SP_DEPTH];

  // Frame store.
  always_ff @(posedge clk) begin
    if (pix_we) begin
      frame_mem[pix_waddr] <= pix_wdata;
    end
    if (pix_re) begin
      pix_rdata <= frame_mem[pix_raddr];
    end
  end

  // Range-weight table.
  always_ff @(posedge clk) begin
    if (rng_we) begin
      range_mem[rng_waddr] <= rng_wdata;
    end
    if (rng_re) begin
      rng_rdata <= range_mem[rng_raddr];
    end
  end

  // Spatial-weight table.
  always_ff @(posedge clk) begin
    if (sp_we) begin
      spat_mem[sp_waddr] <= sp_wdata;
    end
    if (sp_re) begin
      sp_rdata <= spat_mem[sp_raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rbf_mac.sv
// ---------------------------------------------------------------------------
// rbf_mac
// Shared multiplier with per-channel weight and weighted-sample sums.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbf_mac
  import rbf_pkg::*;
#(
  parameter int WSUM_W = 25,
  parameter int PSUM_W = 33
) (
  input  wire logic                clk,
  input  wire mac_ctrl_t           ctrl,
  input  wire logic [WEIGHT_W-1:0] spatial_w,
  input  wire logic [WEIGHT_W-1:0] range_w,
  input  wire logic [SAMPLE_W-1:0] sample,
  output logic      [WSUM_W-1:0]   wsum_o,
  output logic      [PSUM_W-1:0]   psum_o
);

  localparam int MUL_W = WT_W + WEIGHT_W;

  logic [MUL_W-1:0]  prod_r;
  logic [WSUM_W-1:0] wsum_r [3];
  logic [PSUM_W-1:0] psum_r [3];
  logic [WT_W-1:0]   wt;
  logic [WT_W-1:0]   mul_a;
  logic [WEIGHT_W-1:0] mul_b;

  // Combined weight, truncated back to Q2.15.
  assign wt = prod_r[WEIGHT_FRACTION_BITS +: WT_W];

  // Operand selection for the single multiplier.
  always_comb begin
    if (ctrl.mul_weight) begin
      mul_a = {1'b0, spatial_w};
      mul_b = range_w;
    end else begin
      mul_a = wt;
      mul_b = {{(WEIGHT_W-SAMPLE_W){1'b0}}, sample};
    end
  end

  // Product register and accumulators.
  always_ff @(posedge clk) begin
    if (ctrl.mul_weight || ctrl.mul_sample) begin
      prod_r <= mul_a * mul_b;
    end
    if (ctrl.clear) begin
      for (int k = 0; k < 3; k++) begin
        wsum_r[k] <= '0;
        psum_r[k] <= '0;
      end
    end else begin
      if (ctrl.mul_sample) begin
        wsum_r[ctrl.ch] <= wsum_r[ctrl.ch] + WSUM_W'(wt);
      end
      if (ctrl.accumulate) begin
        psum_r[ctrl.ch] <= psum_r[ctrl.ch] + PSUM_W'(prod_r);
      end
    end
  end

  assign wsum_o = wsum_r[ctrl.ch];
  assign psum_o = psum_r[ctrl.ch];

endmodule

`default_nettype wire

// File: rtl/core/rbf_div.sv
// ---------------------------------------------------------------------------
// rbf_div
// Restoring divider, one quotient bit per cycle, result clamped to 255.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbf_div
  import rbf_pkg::*;
#(
  parameter int N = 33,
  parameter int D = 25
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [N-1:0]        dividend,
  input  wire logic [D-1:0]        divisor,
  output logic                     done,
  output logic      [SAMPLE_W-1:0] quot
);

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]     dq_r;
  logic [D-1:0]     div_r;
  logic [D-1:0]     rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             zero_r;
  logic [D:0]       rem_sh;
  logic [D:0]       rem_sub;
  logic             ge;

  // One restoring step.
  assign rem_sh  = {rem_r, dq_r[N-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  // Control: a run ends with a done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r   <= dividend;
      div_r  <= divisor;
      rem_r  <= '0;
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      dq_r  <= {dq_r[N-2:0], ge};
      rem_r <= ge ? rem_sub[D-1:0] : rem_sh[D-1:0];
    end
  end

  assign done = done_r;

  // A zero weight sum gives zero; large quotients saturate.
  always_comb begin
    if (zero_r) begin
      quot = '0;
    end else if (|dq_r[N-1:SAMPLE_W]) begin
      quot = SAMPLE_MAX;
    end else begin
      quot = dq_r[SAMPLE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rgb_bilateral_filter.sv
// Load words give no result.
// A filter word reads the centre, then for each window position inside the image makes
// one frame read, then three range reads through one shared multiplier, skips positions
// outside, and then runs a serial division for each channel. One word at a time.
// Reset (rst_n, synchronous) clears control, sets 128 x 128, radius 2; stores stay unset.
// ---------------------------------------------------------------------------
// rgb_bilateral_filter
// Bilateral filter over an RGB frame store, sequenced around one shared
// multiply-accumulate unit and one serial divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_bilateral_filter_defines.svh"

module rgb_bilateral_filter
  import rbf_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire rbf_in_t    in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output rbf_out_t        out_word,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int SPAN     = MAX_RADIUS + 1;
  localparam int SP_DEPTH = SPAN * SPAN;
  localparam int SI_W     = SP_DEPTH > 1 ? $clog2(SP_DEPTH) : 1;
  localparam int RW       = MAX_RADIUS > 0 ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int OFF_W    = RW + 1;
  localparam int CW       = (OFF_W > 8 ? OFF_W : 8) + 1;
  localparam int WSUM_W   = WT_W + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int PSUM_W   = WSUM_W + SAMPLE_W;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_CEN   = 11'b000_0000_0010,
    ST_NB    = 11'b000_0000_0100,
    ST_FETCH = 11'b000_0000_1000,
    ST_RRD   = 11'b000_0001_0000,
    ST_MUL   = 11'b000_0010_0000,
    ST_WGT   = 11'b000_0100_0000,
    ST_ACC   = 11'b000_1000_0000,
    ST_DST   = 11'b001_0000_0000,
    ST_DWT   = 11'b010_0000_0000,
    ST_FIN   = 11'b100_0000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           ch_r, ch_nxt;
  logic signed [OFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [COORD_W-1:0]   x_r, y_r;
  logic [PIX_W-1:0]     centre_r, nb_r;
  logic [WEIGHT_W-1:0]  sw_r;
  logic [SAMPLE_W-1:0]  res_r [3];
  logic                 out_valid_r;
  rbf_out_t             out_word_r;
  logic [7:0]           cfg_width_r, cfg_height_r;
  logic [3:0]           cfg_radius_r;

  logic                 accept;
  logic [7:0]           w_eff, h_eff;
  logic [RW-1:0]        rad;
  logic signed [OFF_W-1:0] rad_s, neg_rad_s;
  logic signed [CW-1:0] row_s, col_s;
  logic                 in_image;
  logic                 last_pos;
  logic [OFF_W-1:0]     ndx, ndy;
  logic [RW-1:0]        adx, ady;
  logic [SAMPLE_W-1:0]  ca, cb, diff;

  logic [PIX_W-1:0]     pix_rdata;
  logic [WEIGHT_W-1:0]  rng_rdata, sp_rdata;
  logic                 pix_re;
  logic [FRAME_AW-1:0]  pix_raddr;
  logic [SI_W-1:0]      sp_waddr, sp_raddr;
  logic                 sp_we;
  mac_ctrl_t            mac_ctrl;
  logic [WSUM_W-1:0]    wsum;
  logic [PSUM_W-1:0]    psum;
  logic                 div_start, div_done;
  logic [SAMPLE_W-1:0]  div_quot;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Effective geometry, saturated to the store size.
  assign w_eff     = (int'(cfg_width_r) > MAX_WIDTH) ? 8'(MAX_WIDTH) : cfg_width_r;
  assign h_eff     = (int'(cfg_height_r) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : cfg_height_r;
  assign rad       = (int'(cfg_radius_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_radius_r);
  assign rad_s     = $signed({1'b0, rad});
  assign neg_rad_s = -rad_s;

  // Neighbour position and its test against the image bounds.
  assign row_s  = $signed({{(CW-COORD_W){1'b0}}, y_r})
                + $signed({{(CW-OFF_W){dy_r[OFF_W-1]}}, dy_r});
  assign col_s  = $signed({{(CW-COORD_W){1'b0}}, x_r})
                + $signed({{(CW-OFF_W){dx_r[OFF_W-1]}}, dx_r});
  assign in_image = !row_s[CW-1] && (row_s < $signed({{(CW-8){1'b0}}, h_eff}))
                 && !col_s[CW-1] && (col_s < $signed({{(CW-8){1'b0}}, w_eff}));
  assign last_pos = (dx_r == rad_s) && (dy_r == rad_s);

  // Absolute offsets address the spatial table.
  assign ndx = -dx_r;
  assign ndy = -dy_r;
  assign adx = dx_r[OFF_W-1] ? ndx[RW-1:0] : dx_r[RW-1:0];
  assign ady = dy_r[OFF_W-1] ? ndy[RW-1:0] : dy_r[RW-1:0];
  assign sp_raddr = SI_W'(int'(ady) * SPAN + int'(adx));
  assign sp_waddr = SI_W'(int'(in_word.y_coord) * SPAN + int'(in_word.x_coord));
  assign sp_we    = accept && (in_word.operation == OP_LOAD_SPATIAL)
                 && (int'(in_word.x_coord) <= MAX_RADIUS)
                 && (int'(in_word.y_coord) <= MAX_RADIUS);

  // Channel difference for the range lookup.
  assign ca   = centre_r[SAMPLE_W*ch_r +: SAMPLE_W];
  assign cb   = nb_r[SAMPLE_W*ch_r +: SAMPLE_W];
  assign diff = (ca > cb) ? (ca - cb) : (cb - ca);

  // Frame reads: the centre at acceptance, neighbours from the window walk.
  always_comb begin
    pix_re    = 1'b0;
    pix_raddr = {in_word.y_coord, in_word.x_coord};
    if (state_r == ST_IDLE) begin
      pix_re = accept && (in_word.operation == OP_FILTER);
    end else if (state_r == ST_NB) begin
      pix_re    = in_image;
      pix_raddr = {row_s[COORD_W-1:0], col_s[COORD_W-1:0]};
    end
  end

  rbf_store #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_store (
    .clk       (clk),
    .pix_we    (accept && (in_word.operation == OP_LOAD_PIXEL)),
    .pix_waddr ({in_word.y_coord, in_word.x_coord}),
    .pix_wdata ({in_word.blue_in, in_word.green_in, in_word.red_in}),
    .pix_re    (pix_re),
    .pix_raddr (pix_raddr),
    .pix_rdata (pix_rdata),
    .rng_we    (accept && (in_word.operation == OP_LOAD_RANGE)),
    .rng_waddr (in_word.table_index),
    .rng_wdata (in_word.weight_value),
    .rng_re    (state_r == ST_RRD),
    .rng_raddr (diff),
    .rng_rdata (rng_rdata),
    .sp_we     (sp_we),
    .sp_waddr  (sp_waddr),
    .sp_wdata  (in_word.weight_value),
    .sp_re     ((state_r == ST_NB) && in_image),
    .sp_raddr  (sp_raddr),
    .sp_rdata  (sp_rdata)
  );

  // Multiply-accumulate control follows the sequencer state.
  always_comb begin
    mac_ctrl.clear      = accept && (in_word.operation == OP_FILTER);
    mac_ctrl.mul_weight = (state_r == ST_MUL);
    mac_ctrl.mul_sample = (state_r == ST_WGT);
    mac_ctrl.accumulate = (state_r == ST_ACC);
    mac_ctrl.ch         = ch_r;
  end

  rbf_mac #(
    .WSUM_W (WSUM_W),
    .PSUM_W (PSUM_W)
  ) u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .spatial_w (sw_r),
    .range_w   (rng_rdata),
    .sample    (cb),
    .wsum_o    (wsum),
    .psum_o    (psum)
  );

  assign div_start = (state_r == ST_DST);

  rbf_div #(
    .N (PSUM_W),
    .D (WSUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (psum),
    .divisor  (wsum),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_word.operation == OP_FILTER)) begin
          state_nxt = ST_CEN;
          ch_nxt    = 2'd0;
          dx_nxt    = neg_rad_s;
          dy_nxt    = neg_rad_s;
        end
      end
      ST_CEN: begin
        if (({1'b0, x_r} >= w_eff) || ({1'b0, y_r} >= h_eff)) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_NB;
        end
      end
      ST_NB: begin
        if (in_image) begin
          state_nxt = ST_FETCH;
        end else if (last_pos) begin
          state_nxt = ST_DST;
        end else if (dx_r == rad_s) begin
          dx_nxt = neg_rad_s;
          dy_nxt = dy_r + 1'b1;
        end else begin
          dx_nxt = dx_r + 1'b1;
        end
      end
      ST_FETCH: state_nxt = ST_RRD;
      ST_RRD:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_WGT;
      ST_WGT:   state_nxt = ST_ACC;
      ST_ACC: begin
        if (ch_r != 2'd2) begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = ST_RRD;
        end else begin
          ch_nxt = 2'd0;
          if (last_pos) begin
            state_nxt = ST_DST;
          end else begin
            state_nxt = ST_NB;
            if (dx_r == rad_s) begin
              dx_nxt = neg_rad_s;
              dy_nxt = dy_r + 1'b1;
            end else begin
              dx_nxt = dx_r + 1'b1;
            end
          end
        end
      end
      ST_DST:   state_nxt = ST_DWT;
      ST_DWT: begin
        if (div_done) begin
          if (ch_r == 2'd2) begin
            state_nxt = ST_FIN;
            ch_nxt    = 2'd0;
          end else begin
            state_nxt = ST_DST;
            ch_nxt    = ch_r + 1'b1;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= 2'd0;
      dx_r        <= '0;
      dy_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      if ((state_r == ST_FIN) && !out_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= 8'd128;
      cfg_height_r <= 8'd128;
      cfg_radius_r <= 4'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   cfg_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT:  cfg_height_r <= cfg_data;
        CFG_FILTER_RADIUS: cfg_radius_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept && (in_word.operation == OP_FILTER)) begin
      x_r <= in_word.x_coord;
      y_r <= in_word.y_coord;
      for (int k = 0; k < 3; k++) begin
        res_r[k] <= '0;
      end
    end
    if (state_r == ST_CEN) begin
      centre_r <= pix_rdata;
    end
    if (state_r == ST_FETCH) begin
      nb_r <= pix_rdata;
      sw_r <= sp_rdata;
    end
    if ((state_r == ST_DWT) && div_done) begin
      res_r[ch_r] <= div_quot;
    end
    if ((state_r == ST_FIN) && !out_valid_r) begin
      out_word_r.out_x     <= x_r;
      out_word_r.out_y     <= y_r;
      out_word_r.out_red   <= res_r[0];
      out_word_r.out_green <= res_r[1];
      out_word_r.out_blue  <= res_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks on the sequencer.
  `RBF_ASSERT_IMPL(a_ch_range, 1'b1, ch_r != 2'd3)
  `RBF_ASSERT_IMPL(a_div_done_wait, div_done, state_r == ST_DWT)
  `RBF_ASSERT_NEXT(a_fin_loads_out, (state_r == ST_FIN) && !out_valid_r, out_valid_r)
  `RBF_ASSERT_IMPL(a_offset_range, (state_r == ST_NB) || (state_r == ST_ACC), (dx_r <= rad_s) && (dx_r >= neg_rad_s) && (dy_r <= rad_s) && (dy_r >= neg_rad_s))

endmodule

`default_nettype wire
